FILE: rtl/adfp_pkg.sv
package adfp_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] BYTE_EOT   = 8'h04;
    localparam logic [7:0] BYTE_ENQ   = 8'h05;
    localparam logic [7:0] BYTE_DC1   = 8'h11;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_NO_START = 2'd1;
    localparam logic [1:0] VERDICT_EARLY    = 2'd2;
    localparam logic [1:0] VERDICT_NO_END   = 2'd3;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_IDENT  = 8'b0000_0010,
        PH_COUNT  = 8'b0000_0100,
        PH_LEAD   = 8'b0000_1000,
        PH_SIGNED = 8'b0001_0000,
        PH_DIGITS = 8'b0010_0000,
        PH_ENDCHK = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic               kind;
        logic [7:0]         value_index;
        logic signed [31:0] parsed_value;
        logic [7:0]         frame_identifier;
        logic [7:0]         value_count;
        logic [1:0]         verdict;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic    en0;
        logic    en1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

FILE: rtl/adfp_digit.sv
module adfp_digit (
    input  logic [31:0]        i_acc,
    input  logic               i_neg,
    input  logic               i_ovf,
    input  logic [3:0]         i_digit,
    output logic [31:0]        o_acc,
    output logic               o_ovf,
    output logic signed [31:0] o_value
);
    logic [35:0] w_next;
    logic [35:0] w_limit;

    assign w_next  = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {32'd0, i_digit};
    assign w_limit = i_neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;

    always_comb begin
        o_acc = i_acc;
        o_ovf = i_ovf;
        if (!i_ovf) begin
            if (w_next > w_limit) begin
                o_ovf = 1'b1;
            end else begin
                o_acc = w_next[31:0];
            end
        end
    end

    // saturate or apply sign
    assign o_value = i_ovf ? w_limit[31:0] : (i_neg ? (32'd0 - i_acc) : i_acc);

endmodule

FILE: rtl/adfp_fsm.sv
module adfp_fsm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    input  logic [7:0]    i_count_offset,
    output adfp_pkg::t_push o_push
);
    import adfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ident, n_ident;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_done,  n_done;
    logic [31:0] r_acc,   n_acc;
    logic        r_ovf,   n_ovf;
    logic        r_neg,   n_neg;

    logic [31:0]        w_dig_acc;
    logic               w_dig_ovf;
    logic signed [31:0] w_value;
    logic               w_is_digit;
    logic               w_is_space;
    logic               w_val_en;
    logic               w_verd_en;
    logic [1:0]         w_verd;
    logic [7:0]         w_done_inc;
    t_result            w_val_res;
    t_result            w_verd_res;

    assign w_is_digit = (i_byte >= BYTE_ZERO) && (i_byte <= BYTE_NINE);
    assign w_is_space = (i_byte == BYTE_SPACE) || ((i_byte >= BYTE_TAB) && (i_byte <= BYTE_CR));
    assign w_done_inc = r_done + 8'd1;

    adfp_digit u_digit (
        .i_acc   (r_acc),
        .i_neg   (r_neg),
        .i_ovf   (r_ovf),
        .i_digit (i_byte[3:0]),
        .o_acc   (w_dig_acc),
        .o_ovf   (w_dig_ovf),
        .o_value (w_value)
    );

    always_comb begin
        n_phase   = r_phase;
        n_ident   = r_ident;
        n_count   = r_count;
        n_done    = r_done;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_neg     = r_neg;
        w_val_en  = 1'b0;
        w_verd_en = 1'b0;
        w_verd    = VERDICT_OK;
        if (i_in_valid) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == BYTE_ENQ || i_byte == BYTE_DC1) begin
                        n_phase = PH_IDENT;
                        if (i_end) begin
                            w_verd_en = 1'b1;
                            w_verd    = VERDICT_EARLY;
                        end
                    end else if (i_end) begin
                        w_verd_en = 1'b1;
                        w_verd    = VERDICT_NO_START;
                    end
                end
                PH_IDENT: begin
                    n_ident   = i_byte;
                    n_phase   = PH_COUNT;
                    w_verd_en = i_end;
                    w_verd    = VERDICT_EARLY;
                end
                PH_COUNT: begin
                    n_count   = i_byte - i_count_offset;
                    n_phase   = (n_count != 8'd0) ? PH_LEAD : PH_ENDCHK;
                    n_acc     = 32'd0;
                    n_ovf     = 1'b0;
                    n_neg     = 1'b0;
                    w_verd_en = i_end;
                    w_verd    = VERDICT_EARLY;
                end
                PH_LEAD, PH_SIGNED, PH_DIGITS: begin
                    if (r_phase == PH_LEAD && w_is_space) begin
                        n_phase = PH_LEAD;
                    end else if (r_phase == PH_LEAD &&
                                 (i_byte == BYTE_PLUS || i_byte == BYTE_MINUS)) begin
                        n_neg   = (i_byte == BYTE_MINUS);
                        n_phase = PH_SIGNED;
                    end else if (w_is_digit) begin
                        n_acc   = w_dig_acc;
                        n_ovf   = w_dig_ovf;
                        n_phase = PH_DIGITS;
                    end else begin
                        // terminator: emit the field
                        w_val_en = 1'b1;
                        n_done   = w_done_inc;
                        n_acc    = 32'd0;
                        n_ovf    = 1'b0;
                        n_neg    = 1'b0;
                        n_phase  = (w_done_inc == r_count) ? PH_ENDCHK : PH_LEAD;
                    end
                    w_verd_en = i_end;
                    w_verd    = VERDICT_EARLY;
                end
                PH_ENDCHK: begin
                    w_verd_en = 1'b1;
                    w_verd    = (i_byte == BYTE_EOT) ? VERDICT_OK : VERDICT_NO_END;
                    n_phase   = PH_DONE;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        w_val_res.kind             = KIND_VALUE;
        w_val_res.value_index      = r_done;
        w_val_res.parsed_value     = w_value;
        w_val_res.frame_identifier = n_ident;
        w_val_res.value_count      = n_count;
        w_val_res.verdict          = VERDICT_OK;
        w_val_res.last_of_run      = !w_verd_en;

        w_verd_res.kind             = KIND_VERDICT;
        w_verd_res.value_index      = 8'd0;
        w_verd_res.parsed_value     = 32'sd0;
        w_verd_res.frame_identifier = n_ident;
        w_verd_res.value_count      = n_count;
        w_verd_res.verdict          = w_verd;
        w_verd_res.last_of_run      = 1'b1;

        o_push.en0  = w_val_en || w_verd_en;
        o_push.en1  = w_val_en && w_verd_en;
        o_push.res0 = w_val_en ? w_val_res : w_verd_res;
        o_push.res1 = w_verd_res;
    end

    // buffer end returns the frame state to its idle values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && i_end)) begin
            r_phase <= PH_HUNT;
            r_ident <= 8'd0;
            r_count <= 8'd0;
            r_done  <= 8'd0;
            r_acc   <= 32'd0;
            r_ovf   <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ident <= n_ident;
            r_count <= n_count;
            r_done  <= n_done;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_neg   <= n_neg;
        end
    end

endmodule

FILE: rtl/adfp_outq.sv
module adfp_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adfp_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_not_empty,
    output logic              o_room,
    output adfp_pkg::t_result o_head
);
    import adfp_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW:0]     n_count;
    logic [QUEUE_AW-1:0]   w_wr_ptr1;
    logic [1:0]            w_push_n;
    logic                  w_pop;

    assign w_pop     = i_pop && (r_count != '0);
    assign w_push_n  = {1'b0, i_push.en0} + {1'b0, i_push.en1};
    assign w_wr_ptr1 = r_wr_ptr + QUEUE_AW'(1);
    assign n_count   = r_count + (QUEUE_AW+1)'(w_push_n) - (QUEUE_AW+1)'(w_pop);

    // room for the item in flight and the next one
    assign o_room      = (r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 4));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.en1) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_AW'(w_push_n);
            r_rd_ptr <= r_rd_ptr + QUEUE_AW'(w_pop);
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("output queue count out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b00, r_count} + {{(QUEUE_AW+1){1'b0}}, w_push_n}) <=
        ((QUEUE_AW+3)'(QUEUE_DEPTH) + {(QUEUE_AW+2)'(0), w_pop}))
        else $error("output queue overrun");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.en1 |-> (i_push.en0 && i_push.res0.kind == KIND_VALUE))
        else $error("second result without a value ahead of it");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0))
        else $error("output queue not empty after reset");
`endif

endmodule

FILE: rtl/ascii_decimal_frame_parser.sv
// a transferred byte goes through the input register and the output queue before its results show
// throughput: one byte per cycle while o_ready holds and each byte causes at most one result;
// a byte that closes a value and ends the buffer gives two results, one by one at the output port
// an eight-entry output queue decouples the sides; input stalls when it holds more than four
// reset: i_rst_n synchronous active low, clears frame state, queue and count_offset
module ascii_decimal_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_buffer_end,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_result_kind,
    output logic [7:0]         o_value_index,
    output logic signed [31:0] o_parsed_value,
    output logic [7:0]         o_frame_identifier,
    output logic [7:0]         o_value_count,
    output logic [1:0]         o_verdict,
    output logic               o_last_of_run
);
    import adfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic [7:0] r_count_offset;
    t_push      w_push;
    t_result    w_head;
    logic       w_room;

    assign o_ready = w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_count_offset <= 8'd0;
        end else begin
            r_in_valid <= i_valid && w_room;
            if (i_cfg_wr_en) begin
                r_count_offset <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_room) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_buffer_end;
        end
    end

    adfp_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (r_in_valid),
        .i_byte         (r_in_byte),
        .i_end          (r_in_end),
        .i_count_offset (r_count_offset),
        .o_push         (w_push)
    );

    adfp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (i_ready),
        .o_not_empty (o_valid),
        .o_room      (w_room),
        .o_head      (w_head)
    );

    assign o_result_kind      = w_head.kind;
    assign o_value_index      = w_head.value_index;
    assign o_parsed_value     = w_head.parsed_value;
    assign o_frame_identifier = w_head.frame_identifier;
    assign o_value_count      = w_head.value_count;
    assign o_verdict          = w_head.verdict;
    assign o_last_of_run      = w_head.last_of_run;

endmodule
